// ===== rtl/connection_admission_controller_defines.svh =====
// ---------------------------------------------------------------------------
// connection admission controller assertion macros
// shared property forms for the admission controller checks
// ---------------------------------------------------------------------------
`ifndef CONNECTION_ADMISSION_CONTROLLER_DEFINES_SVH
`define CONNECTION_ADMISSION_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define CAC_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("admission controller check failed");
`define CAC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("admission controller check failed");
`else
`define CAC_ASSERT_SAME(name, pre, post)
`define CAC_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== rtl/cac_pkg.sv =====
// ---------------------------------------------------------------------------
// cac_pkg
// types, codes and constants of the connection admission controller
// ---------------------------------------------------------------------------
package cac_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [9:0]  LIMIT_FLOOR   = 10'd100;
    localparam logic [9:0]  LIMIT_CEIL    = 10'd1000;
    localparam logic [9:0]  LIMIT_DOWN    = 10'd50;
    localparam logic [9:0]  LIMIT_UP      = 10'd10;
    localparam logic [31:0] RATE_IDLE_SEC = 32'd60;
    localparam logic [13:0] TOTAL_MAX     = 14'd16383;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;
    localparam logic [6:0]  DISTINCT_MAX  = 7'd127;

    typedef enum logic [2:0] {
        REQ_CHECK   = 3'd0,
        REQ_ADD     = 3'd1,
        REQ_REMOVE  = 3'd2,
        REQ_BAN     = 3'd3,
        REQ_UNBAN   = 3'd4,
        REQ_CLEANUP = 3'd5,
        REQ_LOAD    = 3'd6,
        REQ_NONE    = 3'd7
    } t_req;

    localparam logic [2:0] RSN_NONE      = 3'd0;
    localparam logic [2:0] RSN_BANNED    = 3'd1;
    localparam logic [2:0] RSN_GLOBAL    = 3'd2;
    localparam logic [2:0] RSN_LOAD      = 3'd3;
    localparam logic [2:0] RSN_RATE      = 3'd4;
    localparam logic [2:0] RSN_ADDR_FULL = 3'd5;

    localparam logic [1:0] STRAT_GLOBAL = 2'd0;
    localparam logic [1:0] STRAT_ADDR   = 2'd1;
    localparam logic [1:0] STRAT_LOAD   = 2'd2;
    localparam logic [1:0] STRAT_RATE   = 2'd3;

    localparam logic [2:0] CFG_STRATEGY = 3'd0;
    localparam logic [2:0] CFG_ADDR_MAX = 3'd1;
    localparam logic [2:0] CFG_RATE_MAX = 3'd2;
    localparam logic [2:0] CFG_CPU_THR  = 3'd3;
    localparam logic [2:0] CFG_MEM_THR  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LOOK = 2'd1,
        S_EXEC = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic        used;
        logic [31:0] addr;
        logic [7:0]  cnt;
        logic        rv;
        logic [31:0] ws;
        logic [7:0]  rc;
        logic        bv;
        logic [31:0] be;
    } t_entry;

    typedef struct packed {
        logic        write;
        logic        cleanup;
        logic [31:0] now;
        t_entry      entry;
    } t_cmd;

endpackage

// ===== rtl/cac_cell.sv =====
// ---------------------------------------------------------------------------
// cac_cell
// one table slot: address match, free chain link, update and cleanup aging
// ---------------------------------------------------------------------------
module cac_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_addr,
    input  logic            i_sel,
    input  cac_pkg::t_cmd   i_cmd,
    input  logic            i_free_seen,
    output logic            o_free_seen,
    output logic            o_first_free,
    output logic            o_hit,
    output cac_pkg::t_entry o_entry
);

    logic        r_used, r_rv, r_bv;
    logic [7:0]  r_cnt;
    logic [31:0] r_addr, r_ws, r_be;
    logic [7:0]  r_rc;

    logic w_bv_keep, w_rv_keep, w_used_keep;

    assign o_hit        = r_used && (r_addr == i_addr);
    assign o_first_free = !r_used && !i_free_seen;
    assign o_free_seen  = i_free_seen || !r_used;

    always_comb begin
        o_entry = '0;
        if (o_hit) begin
            o_entry = '{used: r_used, addr: r_addr, cnt: r_cnt, rv: r_rv, ws: r_ws,
                        rc: r_rc, bv: r_bv, be: r_be};
        end
    end

    // aging done by every slot at once on a cleanup tick
    always_comb begin
        w_bv_keep   = r_bv && !(r_be < i_cmd.now);
        w_rv_keep   = r_rv && !((i_cmd.now > r_ws) && ((i_cmd.now - r_ws) > cac_pkg::RATE_IDLE_SEC));
        w_used_keep = r_used && ((r_cnt != 8'd0) || w_rv_keep || w_bv_keep);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_cnt  <= 8'd0;
            r_rv   <= 1'b0;
            r_bv   <= 1'b0;
        end else if (i_cmd.write && i_sel) begin
            r_used <= i_cmd.entry.used;
            r_cnt  <= i_cmd.entry.cnt;
            r_rv   <= i_cmd.entry.rv;
            r_bv   <= i_cmd.entry.bv;
        end else if (i_cmd.cleanup && r_used) begin
            r_used <= w_used_keep;
            r_rv   <= w_rv_keep;
            r_bv   <= w_bv_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && i_sel) begin
            r_addr <= i_cmd.entry.addr;
            r_ws   <= i_cmd.entry.ws;
            r_rc   <= i_cmd.entry.rc;
            r_be   <= i_cmd.entry.be;
        end
    end

endmodule

// ===== rtl/connection_admission_controller.sv =====
// ---------------------------------------------------------------------------
// connection_admission_controller
// admission decisions over a table of source addresses held in a row of slots
// ---------------------------------------------------------------------------
// Each request beat passes through accept, a lookup in which every slot
// compares its address and the free chain picks the lowest empty slot, an
// update cycle that decides and writes the chosen slot (a cleanup tick ages
// all slots at once in that same cycle), and a result beat. The next request
// is taken the cycle after the result beat leaves, so no request is taken
// while the last one is still in the slot row, and a stall on m_axis_tready
// holds the next one back. The table needs no clearing after reset.
// Configuration writes are always ready.
`include "connection_admission_controller_defines.svh"

module connection_admission_controller #(
    parameter int TABLE_ENTRIES = cac_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // client_address[31:0], now_seconds[63:32], ban_seconds[79:64],
    // cpu_load[86:80], mem_load[93:87]
    input  logic [95:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted[0], reject_reason[3:1], address_count[11:4], is_banned[12],
    // total_connections[26:13], distinct_addresses[33:27], global_limit[43:34],
    // table_full[44]
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int DW = $clog2(TABLE_ENTRIES + 1);

    cac_pkg::t_state r_state, n_state;

    logic [1:0] r_strategy;
    logic [7:0] r_addr_max, r_rate_max;
    logic [6:0] r_cpu_thr, r_mem_thr;

    cac_pkg::t_req r_req;
    logic [31:0]   r_addr, r_now;
    logic [15:0]   r_ban;
    logic [6:0]    r_cpu, r_mem;

    logic [TABLE_ENTRIES-1:0] w_hit_vec, w_free_vec, r_hit_vec, r_free_vec;
    logic [TABLE_ENTRIES:0]   w_seen;
    cac_pkg::t_entry          w_masked [TABLE_ENTRIES];
    cac_pkg::t_entry          w_gather, r_ent;
    logic                     r_hit_any, r_free_any;

    logic [13:0]   r_total, n_total;
    logic [DW-1:0] r_distinct, n_distinct;
    logic [9:0]    r_limit, n_limit;
    logic [47:0]   r_out;

    cac_pkg::t_cmd   w_cmd;
    cac_pkg::t_entry n_ent, w_base;
    logic            w_accepted, w_full, w_exists, w_banned;
    logic [2:0]      w_reason;
    logic [32:0]     w_ban_sum;
    logic [7:0]      w_count;
    logic [6:0]      w_distinct_out;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= cac_pkg::STRAT_GLOBAL;
            r_addr_max <= 8'd10;
            r_rate_max <= 8'd50;
            r_cpu_thr  <= 7'd80;
            r_mem_thr  <= 7'd90;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cac_pkg::CFG_STRATEGY: r_strategy <= i_cfg_data[1:0];
                cac_pkg::CFG_ADDR_MAX: r_addr_max <= i_cfg_data;
                cac_pkg::CFG_RATE_MAX: r_rate_max <= i_cfg_data;
                cac_pkg::CFG_CPU_THR:  r_cpu_thr  <= i_cfg_data[6:0];
                cac_pkg::CFG_MEM_THR:  r_mem_thr  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cac_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            cac_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) n_state = cac_pkg::S_LOOK;
            end
            cac_pkg::S_LOOK: n_state = cac_pkg::S_EXEC;
            cac_pkg::S_EXEC: n_state = cac_pkg::S_OUT;
            cac_pkg::S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) n_state = cac_pkg::S_IDLE;
            end
            default: n_state = cac_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req  <= cac_pkg::t_req'(s_axis_tuser);
            r_addr <= s_axis_tdata[31:0];
            r_now  <= s_axis_tdata[63:32];
            r_ban  <= s_axis_tdata[79:64];
            r_cpu  <= s_axis_tdata[86:80];
            r_mem  <= s_axis_tdata[93:87];
        end
    end

    // slot row
    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_slot
        cac_cell u_slot (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_addr       (r_addr),
            .i_sel        (r_hit_any ? r_hit_vec[g] : r_free_vec[g]),
            .i_cmd        (w_cmd),
            .i_free_seen  (w_seen[g]),
            .o_free_seen  (w_seen[g+1]),
            .o_first_free (w_free_vec[g]),
            .o_hit        (w_hit_vec[g]),
            .o_entry      (w_masked[g])
        );
    end

    // at most one slot matches, so an or over the masked slots reads it out
    always_comb begin
        w_gather = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_gather = w_gather | w_masked[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cac_pkg::S_LOOK) begin
            r_hit_vec  <= w_hit_vec;
            r_free_vec <= w_free_vec;
            r_hit_any  <= |w_hit_vec;
            r_free_any <= w_seen[TABLE_ENTRIES];
            r_ent      <= w_gather;
        end
    end

    // decision and slot update
    always_comb begin
        w_base = r_ent;
        if (!r_hit_any) begin
            w_base      = '0;
            w_base.used = 1'b1;
            w_base.addr = r_addr;
        end
        n_ent      = w_base;
        w_accepted = 1'b0;
        w_reason   = cac_pkg::RSN_NONE;
        w_full     = 1'b0;
        w_cmd      = '0;
        w_ban_sum  = {1'b0, r_now} + {17'd0, r_ban};
        n_total    = r_total;
        n_distinct = r_distinct;
        n_limit    = r_limit;
        case (r_req)
            cac_pkg::REQ_CHECK: begin
                if (r_hit_any && r_ent.bv && (r_ent.be > r_now)) begin
                    w_reason = cac_pkg::RSN_BANNED;
                end else begin
                    if (r_hit_any && r_ent.bv) begin
                        n_ent.bv    = 1'b0;
                        n_ent.used  = (r_ent.cnt != 8'd0) || r_ent.rv;
                        w_cmd.write = 1'b1;
                    end
                    case (r_strategy)
                        cac_pkg::STRAT_GLOBAL: begin
                            if (r_total < 14'(r_limit)) w_accepted = 1'b1;
                            else w_reason = cac_pkg::RSN_GLOBAL;
                        end
                        cac_pkg::STRAT_ADDR: begin
                            if (n_ent.cnt < r_addr_max) w_accepted = 1'b1;
                            else w_reason = cac_pkg::RSN_ADDR_FULL;
                        end
                        cac_pkg::STRAT_LOAD: begin
                            if ((r_cpu < r_cpu_thr) && (r_mem < r_mem_thr)) w_accepted = 1'b1;
                            else w_reason = cac_pkg::RSN_LOAD;
                        end
                        default: begin
                            if (!r_hit_any || !r_ent.rv) begin
                                w_accepted = 1'b1;
                            end else if (r_now > r_ent.ws) begin
                                n_ent.ws    = r_now;
                                n_ent.rc    = 8'd1;
                                w_cmd.write = 1'b1;
                                w_accepted  = 1'b1;
                            end else if (r_ent.rc < r_rate_max) begin
                                w_accepted = 1'b1;
                            end else begin
                                w_reason = cac_pkg::RSN_RATE;
                            end
                        end
                    endcase
                end
            end
            cac_pkg::REQ_ADD: begin
                if (!r_hit_any && !r_free_any) begin
                    w_full = 1'b1;
                end else begin
                    w_cmd.write = 1'b1;
                    if (w_base.cnt < cac_pkg::COUNT_MAX) n_ent.cnt = w_base.cnt + 8'd1;
                    if (r_total < cac_pkg::TOTAL_MAX) n_total = r_total + 14'd1;
                    if (w_base.cnt == 8'd0) n_distinct = r_distinct + DW'(1);
                    if (!w_base.rv || (r_now > w_base.ws)) begin
                        n_ent.rv = 1'b1;
                        n_ent.ws = r_now;
                        n_ent.rc = 8'd1;
                    end else if (w_base.rc < cac_pkg::COUNT_MAX) begin
                        n_ent.rc = w_base.rc + 8'd1;
                    end
                end
            end
            cac_pkg::REQ_REMOVE: begin
                if (r_hit_any) begin
                    w_cmd.write = 1'b1;
                    if (r_ent.cnt > 8'd1) begin
                        n_ent.cnt = r_ent.cnt - 8'd1;
                        if (r_total != 14'd0) n_total = r_total - 14'd1;
                    end else begin
                        n_total    = (r_total > 14'(r_ent.cnt)) ? r_total - 14'(r_ent.cnt)
                                                                 : 14'd0;
                        n_ent.cnt  = 8'd0;
                        n_ent.rv   = 1'b0;
                        n_ent.used = r_ent.bv;
                        if (r_ent.cnt == 8'd1) n_distinct = r_distinct - DW'(1);
                    end
                end
            end
            cac_pkg::REQ_BAN: begin
                if (!r_hit_any && !r_free_any) begin
                    w_full = 1'b1;
                end else begin
                    w_cmd.write = 1'b1;
                    n_ent.bv    = 1'b1;
                    n_ent.be    = w_ban_sum[32] ? 32'hFFFF_FFFF : w_ban_sum[31:0];
                end
            end
            cac_pkg::REQ_UNBAN: begin
                if (r_hit_any) begin
                    w_cmd.write = 1'b1;
                    n_ent.bv    = 1'b0;
                    n_ent.used  = (r_ent.cnt != 8'd0) || r_ent.rv;
                end
            end
            cac_pkg::REQ_CLEANUP: w_cmd.cleanup = 1'b1;
            cac_pkg::REQ_LOAD: begin
                if (r_strategy == cac_pkg::STRAT_LOAD) begin
                    if ((r_cpu > r_cpu_thr) || (r_mem > r_mem_thr)) begin
                        n_limit = (r_limit >= cac_pkg::LIMIT_FLOOR + cac_pkg::LIMIT_DOWN)
                                ? r_limit - cac_pkg::LIMIT_DOWN : cac_pkg::LIMIT_FLOOR;
                    end else begin
                        n_limit = (r_limit + cac_pkg::LIMIT_UP <= cac_pkg::LIMIT_CEIL)
                                ? r_limit + cac_pkg::LIMIT_UP : cac_pkg::LIMIT_CEIL;
                    end
                end
            end
            default: ;
        endcase
        if (r_state != cac_pkg::S_EXEC) begin
            w_cmd.write   = 1'b0;
            w_cmd.cleanup = 1'b0;
        end
        w_cmd.now   = r_now;
        w_cmd.entry = n_ent;

        // a freed slot has a zero count, so the count still reads right
        w_exists = r_hit_any || (w_cmd.write &&
                   ((r_req == cac_pkg::REQ_ADD) || (r_req == cac_pkg::REQ_BAN)));
        w_count  = w_exists ? n_ent.cnt : 8'd0;
        w_banned = w_exists && n_ent.bv && (n_ent.be > r_now);
        w_distinct_out = ({{(32-DW){1'b0}}, n_distinct} > 32'(cac_pkg::DISTINCT_MAX))
                       ? cac_pkg::DISTINCT_MAX : 7'(n_distinct);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= 14'd0;
            r_distinct <= '0;
            r_limit    <= cac_pkg::LIMIT_CEIL;
        end else if (r_state == cac_pkg::S_EXEC) begin
            r_total    <= n_total;
            r_distinct <= n_distinct;
            r_limit    <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cac_pkg::S_EXEC) begin
            r_out <= {3'd0, w_full, n_limit, w_distinct_out, n_total, w_banned,
                      w_count, w_reason, w_accepted};
        end
    end

    assign m_axis_tdata = r_out;

    `CAC_ASSERT_NEXT(a_accept_to_lookup, s_axis_tvalid && s_axis_tready, r_state == cac_pkg::S_LOOK)
    `CAC_ASSERT_SAME(a_single_match, r_state == cac_pkg::S_LOOK, $onehot0(w_hit_vec))
    `CAC_ASSERT_SAME(a_limit_range, 1'b1, (r_limit >= cac_pkg::LIMIT_FLOOR) && (r_limit <= cac_pkg::LIMIT_CEIL))
    `CAC_ASSERT_SAME(a_full_no_write, (r_state == cac_pkg::S_EXEC) && w_full, !w_cmd.write)

endmodule

// ===== sim/tb_connection_admission_controller.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_connection_admission_controller
// drives request beats with random gaps and stalls and compares every status
// beat against a behavioral table of source entries kept alongside the block
// ---------------------------------------------------------------------------
module tb_connection_admission_controller;

    localparam int N_SLOTS     = 64;
    localparam int N_RANDOM    = 800;
    localparam int STALL_LIMIT = 20000;

    // packed from table_full down to accepted, matching the status beat
    typedef struct packed {
        logic        full;
        logic [9:0]  limit;
        logic [6:0]  distinct;
        logic [13:0] total;
        logic        banned;
        logic [7:0]  cnt;
        logic [2:0]  why;
        logic        ok;
    } t_status;

    typedef struct {
        cac_pkg::t_req req;
        logic [31:0]   addr;
        logic [31:0]   now;
        logic [15:0]   bsec;
        logic [6:0]    cpu;
        logic [6:0]    mem;
        logic          typed;
        t_status       want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    connection_admission_controller dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow table
    logic        sh_used [N_SLOTS];
    logic [31:0] sh_addr [N_SLOTS];
    logic [7:0]  sh_cnt  [N_SLOTS];
    logic        sh_rv   [N_SLOTS];
    logic [31:0] sh_ws   [N_SLOTS];
    logic [7:0]  sh_rc   [N_SLOTS];
    logic        sh_bv   [N_SLOTS];
    logic [31:0] sh_be   [N_SLOTS];
    logic [13:0] sh_total;
    logic [9:0]  sh_limit;
    logic [1:0]  cf_strat;
    logic [7:0]  cf_addr_max, cf_rate_max;
    logic [6:0]  cf_cpu, cf_mem;

    t_status status_q[$];
    t_status typed_q[$];
    logic    typed_flag_q[$];

    int errors = 0, n_out = 0, n_in = 0, n_rej = 0, n_full = 0;
    int snd_idle = 29, rcv_idle = 68;
    bit hold_rcv = 1'b0;
    int idle_cycles = 0;

    function automatic int slot_of(logic [31:0] a);
        for (int i = 0; i < N_SLOTS; i++)
            if (sh_used[i] && sh_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic int claim_slot(logic [31:0] a);
        int e;
        e = slot_of(a);
        if (e >= 0) return e;
        for (int i = 0; i < N_SLOTS; i++)
            if (!sh_used[i]) begin
                sh_used[i] = 1'b1; sh_addr[i] = a; sh_cnt[i] = 0;
                sh_rv[i] = 1'b0; sh_bv[i] = 1'b0;
                return i;
            end
        return -1;
    endfunction

    function automatic void release_if_idle(int i);
        if (sh_cnt[i] == 0 && !sh_rv[i] && !sh_bv[i]) sh_used[i] = 1'b0;
    endfunction

    function automatic t_status admit_step(cac_pkg::t_req rq, logic [31:0] a,
                                           logic [31:0] now, logic [15:0] bsec,
                                           logic [6:0] cpu, logic [6:0] mem);
        t_status s;
        int e, d;
        s = '0;
        e = slot_of(a);
        case (rq)
            cac_pkg::REQ_CHECK: begin
                if (e >= 0 && sh_bv[e] && sh_be[e] > now) s.why = cac_pkg::RSN_BANNED;
                else begin
                    if (e >= 0 && sh_bv[e]) begin
                        sh_bv[e] = 1'b0;
                        release_if_idle(e);
                        e = slot_of(a);
                    end
                    case (cf_strat)
                        cac_pkg::STRAT_GLOBAL: if (sh_total < {4'd0, sh_limit}) s.ok = 1;
                                               else s.why = cac_pkg::RSN_GLOBAL;
                        cac_pkg::STRAT_ADDR:
                            if ((e >= 0 ? sh_cnt[e] : 8'd0) < cf_addr_max) s.ok = 1;
                            else s.why = cac_pkg::RSN_ADDR_FULL;
                        cac_pkg::STRAT_LOAD: if (cpu < cf_cpu && mem < cf_mem) s.ok = 1;
                                             else s.why = cac_pkg::RSN_LOAD;
                        default: begin
                            if (e < 0 || !sh_rv[e]) s.ok = 1;
                            else if (now > sh_ws[e]) begin
                                sh_ws[e] = now; sh_rc[e] = 1; s.ok = 1;
                            end else if (sh_rc[e] < cf_rate_max) s.ok = 1;
                            else s.why = cac_pkg::RSN_RATE;
                        end
                    endcase
                end
            end
            cac_pkg::REQ_ADD: begin
                e = claim_slot(a);
                if (e < 0) s.full = 1;
                else begin
                    if (sh_cnt[e] < cac_pkg::COUNT_MAX) sh_cnt[e]++;
                    if (sh_total < cac_pkg::TOTAL_MAX) sh_total++;
                    if (!sh_rv[e] || now > sh_ws[e]) begin
                        sh_rv[e] = 1; sh_ws[e] = now; sh_rc[e] = 1;
                    end else if (sh_rc[e] < cac_pkg::COUNT_MAX) sh_rc[e]++;
                end
            end
            cac_pkg::REQ_REMOVE: if (e >= 0) begin
                if (sh_cnt[e] > 1) begin
                    sh_cnt[e]--;
                    if (sh_total > 0) sh_total--;
                end else begin
                    sh_total = (sh_total > sh_cnt[e]) ? sh_total - sh_cnt[e] : 14'd0;
                    sh_cnt[e] = 0; sh_rv[e] = 0;
                    release_if_idle(e);
                end
            end
            cac_pkg::REQ_BAN: begin
                e = claim_slot(a);
                if (e < 0) s.full = 1;
                else begin
                    sh_bv[e] = 1;
                    sh_be[e] = (now > 32'hFFFF_FFFF - bsec) ? 32'hFFFF_FFFF : now + bsec;
                end
            end
            cac_pkg::REQ_UNBAN: if (e >= 0) begin
                sh_bv[e] = 0;
                release_if_idle(e);
            end
            cac_pkg::REQ_CLEANUP: for (int i = 0; i < N_SLOTS; i++) if (sh_used[i]) begin
                if (sh_bv[i] && sh_be[i] < now) sh_bv[i] = 0;
                if (sh_rv[i] && now > sh_ws[i] && now - sh_ws[i] > cac_pkg::RATE_IDLE_SEC)
                    sh_rv[i] = 0;
                release_if_idle(i);
            end
            cac_pkg::REQ_LOAD: if (cf_strat == cac_pkg::STRAT_LOAD) begin
                if (cpu > cf_cpu || mem > cf_mem)
                    sh_limit = (sh_limit >= cac_pkg::LIMIT_FLOOR + cac_pkg::LIMIT_DOWN) ?
                               sh_limit - cac_pkg::LIMIT_DOWN : cac_pkg::LIMIT_FLOOR;
                else
                    sh_limit = (sh_limit + cac_pkg::LIMIT_UP <= cac_pkg::LIMIT_CEIL) ?
                               sh_limit + cac_pkg::LIMIT_UP : cac_pkg::LIMIT_CEIL;
            end
            default: ;
        endcase
        e = slot_of(a);
        d = 0;
        for (int i = 0; i < N_SLOTS; i++)
            if (sh_used[i] && sh_cnt[i] > 0 && d < cac_pkg::DISTINCT_MAX) d++;
        s.cnt = (e >= 0) ? sh_cnt[e] : 8'd0;
        s.banned = (e >= 0 && sh_bv[e] && sh_be[e] > now);
        s.total = sh_total;
        s.distinct = d[6:0];
        s.limit = sh_limit;
        return s;
    endfunction

    task automatic send_request(cac_pkg::t_req rq, logic [31:0] a, logic [31:0] now,
                                logic [15:0] bsec, logic [6:0] cpu, logic [6:0] mem,
                                bit typed, t_status want);
        t_status s;
        while (snd_idle > 0 && $urandom_range(99, 0) < snd_idle) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq;
        s_axis_tdata <= {2'b00, mem, cpu, bsec, now, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        s = admit_step(rq, a, now, bsec, cpu, mem);
        status_q.push_back(s);
        typed_q.push_back(want);
        typed_flag_q.push_back(typed);
        n_in++;
        // the block takes no other beat until the status beat of this one has left anyway
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            cac_pkg::CFG_STRATEGY: cf_strat = val[1:0];
            cac_pkg::CFG_ADDR_MAX: cf_addr_max = val;
            cac_pkg::CFG_RATE_MAX: cf_rate_max = val;
            cac_pkg::CFG_CPU_THR:  cf_cpu = val[6:0];
            cac_pkg::CFG_MEM_THR:  cf_mem = val[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) m_axis_tready <= !hold_rcv && ($urandom_range(99, 0) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        t_status got, want;
        bit typed;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[44:0];
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected status beat %h", got);
            end else begin
                want = status_q.pop_front();
                typed = typed_flag_q.pop_front();
                if (typed && typed_q[0] != want) begin
                    errors++;
                    if (errors <= 10) $display("table row disagrees: typed %h predicted %h",
                                               typed_q[0], want);
                end
                void'(typed_q.pop_front());
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display("status mismatch: exp ok%0d why%0d cnt%0d ban%0d ",
                                 want.ok, want.why, want.cnt, want.banned,
                                 "tot%0d dist%0d lim%0d full%0d ",
                                 want.total, want.distinct, want.limit, want.full,
                                 "got ok%0d why%0d cnt%0d ban%0d ",
                                 got.ok, got.why, got.cnt, got.banned,
                                 "tot%0d dist%0d lim%0d full%0d",
                                 got.total, got.distinct, got.limit, got.full);
                end
                if (got.why != cac_pkg::RSN_NONE) n_rej++;
                if (got.full) n_full++;
            end
            n_out++;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n && (s_axis_tvalid || status_q.size() != 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_status typed_status(int ok, int why, int cnt, int bn, int tot,
                                             int dcount, int lim, int full);
        t_status s;
        s.ok       = 1'(ok);
        s.why      = 3'(why);
        s.cnt      = 8'(cnt);
        s.banned   = 1'(bn);
        s.total    = 14'(tot);
        s.distinct = 7'(dcount);
        s.limit    = 10'(lim);
        s.full     = 1'(full);
        return s;
    endfunction

    t_row dir_rows[$];
    logic [31:0] pool[8];

    task automatic random_phase(int count);
        cac_pkg::t_req rq;
        logic [31:0] a, now;
        logic [15:0] bsec;
        int pick;
        now = $urandom_range(1000, 0);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 30) rq = cac_pkg::REQ_CHECK;
            else if (pick < 55) rq = cac_pkg::REQ_ADD;
            else if (pick < 70) rq = cac_pkg::REQ_REMOVE;
            else if (pick < 78) rq = cac_pkg::REQ_BAN;
            else if (pick < 84) rq = cac_pkg::REQ_UNBAN;
            else if (pick < 90) rq = cac_pkg::REQ_CLEANUP;
            else if (pick < 98) rq = cac_pkg::REQ_LOAD;
            else rq = cac_pkg::REQ_NONE;
            a = ($urandom_range(9, 0) == 0) ? $urandom() : pool[$urandom_range(7, 0)];
            if ($urandom_range(3, 0) != 0) now = now + $urandom_range(3, 0);
            else now = $urandom_range(3, 0) == 0 ? $urandom() : now + $urandom_range(120, 0);
            bsec = $urandom_range(3, 0) == 0 ? 16'($urandom()) : 16'($urandom_range(20, 0));
            send_request(rq, a, now, bsec, 7'($urandom_range(100, 0)),
                         7'($urandom_range(100, 0)), 1'b0, '0);
        end
    endtask

    initial begin
        logic [31:0] addr_hi;
        cf_strat = cac_pkg::STRAT_GLOBAL; cf_addr_max = 8'd10; cf_rate_max = 8'd50;
        cf_cpu = 7'd80; cf_mem = 7'd90;
        for (int i = 0; i < N_SLOTS; i++) begin
            sh_used[i] = 0; sh_cnt[i] = 0; sh_rv[i] = 0; sh_bv[i] = 0;
            sh_addr[i] = 0; sh_ws[i] = 0; sh_rc[i] = 0; sh_be[i] = 0;
        end
        sh_total = 0; sh_limit = cac_pkg::LIMIT_CEIL;
        for (int i = 0; i < 8; i++) pool[i] = $urandom();
        pool[0] = 32'h0; pool[1] = 32'hFFFF_FFFF;
        addr_hi = 32'hFFFF_FFFF;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: typed expectations where the value is obvious
        dir_rows = '{
            '{cac_pkg::REQ_CHECK, 32'h0, 32'h0, 16'h0, 7'd0, 7'd0, 1'b1,
              typed_status(1, cac_pkg::RSN_NONE, 0, 0, 0, 0, 1000, 0)},
            '{cac_pkg::REQ_ADD, addr_hi, 32'd5, 16'h0, 7'd100, 7'd100, 1'b1,
              typed_status(0, cac_pkg::RSN_NONE, 1, 0, 1, 1, 1000, 0)},
            '{cac_pkg::REQ_ADD, addr_hi, 32'd5, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_BAN, addr_hi, 32'hFFFF_FFF0, 16'hFFFF, 7'd0, 7'd0, 1'b1,
              typed_status(0, cac_pkg::RSN_NONE, 2, 1, 2, 1, 1000, 0)},
            '{cac_pkg::REQ_CHECK, addr_hi, 32'd10, 16'h0, 7'd0, 7'd0, 1'b1,
              typed_status(0, cac_pkg::RSN_BANNED, 2, 1, 2, 1, 1000, 0)},
            '{cac_pkg::REQ_UNBAN, addr_hi, 32'd10, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_BAN, 32'h0A00_0001, 32'd100, 16'd5, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_CHECK, 32'h0A00_0001, 32'd105, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_REMOVE, addr_hi, 32'd11, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_REMOVE, addr_hi, 32'd11, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_REMOVE, 32'h1234_5678, 32'd11, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_UNBAN, 32'h1234_5678, 32'd11, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_ADD, 32'h5555_AAAA, 32'd20, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_CLEANUP, 32'h0, 32'd200, 16'h0, 7'd0, 7'd0, 1'b0, '0},
            '{cac_pkg::REQ_LOAD, 32'h0, 32'd200, 16'h0, 7'd100, 7'd100, 1'b0, '0},
            '{cac_pkg::REQ_NONE, 32'hAAAA_5555, 32'hFFFF_FFFF, 16'hFFFF, 7'd127, 7'd127,
              1'b0, '0}
        };
        foreach (dir_rows[r])
            send_request(dir_rows[r].req, dir_rows[r].addr, dir_rows[r].now,
                         dir_rows[r].bsec, dir_rows[r].cpu, dir_rows[r].mem,
                         dir_rows[r].typed, dir_rows[r].want);
        drain();

        // load strategy: drive the limit down to the floor
        write_reg(cac_pkg::CFG_STRATEGY, {6'd0, cac_pkg::STRAT_LOAD});
        write_reg(cac_pkg::CFG_CPU_THR, 8'd0);
        write_reg(cac_pkg::CFG_MEM_THR, 8'd100);
        repeat (20) send_request(cac_pkg::REQ_LOAD, 32'h0, 32'd300, 16'h0, 7'd100, 7'd0,
                                 1'b0, '0);
        send_request(cac_pkg::REQ_CHECK, 32'h0, 32'd300, 16'h0, 7'd0, 7'd0, 1'b0, '0);
        drain();

        // table full: send bans for more addresses than there are slots, then add one more
        for (int i = 0; i < N_SLOTS + 1; i++)
            send_request(cac_pkg::REQ_BAN, 32'hC000_0000 + i, 32'd400, 16'd10, 7'd0, 7'd0,
                         1'b0, '0);
        send_request(cac_pkg::REQ_ADD, 32'hC100_0000, 32'd400, 16'd0, 7'd0, 7'd0, 1'b0, '0);
        send_request(cac_pkg::REQ_CLEANUP, 32'h0, 32'd500, 16'd0, 7'd0, 7'd0, 1'b0, '0);
        drain();

        // phase table: settings including extremes, then random traffic
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin snd_idle = 68; rcv_idle = 29; end
            if (ph == 6) begin snd_idle = 0; rcv_idle = 0; end
            write_reg(cac_pkg::CFG_STRATEGY, {6'd0, ph[1:0]});
            write_reg(cac_pkg::CFG_ADDR_MAX,
                      ph == 0 ? 8'd0 : ph == 1 ? 8'd255 : 8'($urandom_range(4, 1)));
            write_reg(cac_pkg::CFG_RATE_MAX,
                      ph == 2 ? 8'd0 : ph == 3 ? 8'd255 : 8'($urandom_range(4, 1)));
            write_reg(cac_pkg::CFG_CPU_THR,
                      ph == 4 ? 8'd100 : ph == 5 ? 8'd0 : 8'($urandom_range(100, 0)));
            write_reg(cac_pkg::CFG_MEM_THR,
                      ph == 4 ? 8'd0 : ph == 5 ? 8'd100 : 8'($urandom_range(100, 0)));
            if (ph == 6) begin
                // long receiver hold while requests keep coming
                fork
                    begin hold_rcv = 1'b1; repeat (300) @(posedge i_clk); hold_rcv = 1'b0; end
                    random_phase(30);
                join
                drain();
            end
            random_phase(N_RANDOM / 8);
            drain();
        end

        $display("sent %0d requests, checked %0d status beats, %0d refusals, %0d table-full",
                 n_in, n_out, n_rej, n_full);
        if (errors == 0 && status_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("mismatches: %0d", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
